// ===== rtl/core/bpf_pkg.sv =====
package bpf_pkg;

    localparam int POS_W  = 32;
    localparam int DIFF_W = 33;
    localparam int TAG_W  = 31;
    localparam int TYPE_W = 7;
    localparam int MAG_W  = 32;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 2;
    localparam int IN_W   = 264;
    localparam int OUT_W  = 104;

    localparam int NORM_W = 30;
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 34;
    localparam int NUM_W  = 62;
    localparam int DIV_W  = 32;
    localparam int QUO_W  = 31;
    localparam int NORM_TOP = 29;

    localparam logic [ADDR_W-1:0] REG_FORCE_MAG = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TYPE_EN   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_NEWTON    = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic                       active;
        logic                       apply_i;
        logic                       apply_j;
        logic                       zero;
        logic [2:0]                 sgn;
        logic [MAG_W-1:0]           mag;
        logic [2:0][NORM_W-1:0]     a;
    } bpf_ctl_t;

endpackage

// ===== rtl/core/bond_propulsion_force_core.sv =====
// channel  direction  bits  fields (lowest bit up)
// s_       in         264   pos_i_x/y/z, pos_j_x/y/z, tag_i, tag_j, bond_type,
//                           both_in_group, i_owned, j_owned
// m_       out        104   force_x/y/z, bond_active, apply_i, apply_j
// cfg_     in         64    force_magnitude, bond_type_enable, newton_on
//
// one bond per cycle unless the output stalls; pipeline: three normalize stages,
// squares and sum, 31 square root stages (one root bit each), product stage, 31 divide
// stages (one quotient bit each) and the output register
// aresetn is synchronous and clears only the valid bits and the config registers
// the whole pipe holds while m_tvalid is high and m_tready is low
module bond_propulsion_force_core #(
    parameter int NUM_BOND_TYPES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z, tag_i, tag_j, bond_type,
    // both_in_group, i_owned, j_owned
    input  logic [bpf_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // force_x, force_y, force_z, bond_active, apply_i, apply_j, zero fill
    output logic [bpf_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [bpf_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [bpf_pkg::CFG_W-1:0]   cfg_wdata
);
    import bpf_pkg::*;

    logic                  en;
    logic [MAG_W-1:0]      force_mag_reg;
    logic [CFG_W-1:0]      type_en_reg;
    logic                  newton_reg;

    bpf_ctl_t              ctl_c, ctl_d_reg, ctl_e_reg, ctl_s, ctl_f_reg, ctl_q;
    logic [2:0][SQ_W-1:0]  sq_d_reg;
    logic [SUM_W-1:0]      sum_e_reg;
    logic [ROOT_W-1:0]     root_s;
    logic [2:0][NUM_W-1:0] num_f_reg;
    logic [DIV_W-1:0]      div_f_reg;
    logic [2:0][QUO_W-1:0] quo_q;

    logic                  m_valid_reg;
    logic [2:0][POS_W-1:0] force_reg;
    logic                  active_reg, apply_i_reg, apply_j_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_mag_reg <= '0;
            type_en_reg   <= '1;
            newton_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FORCE_MAG: force_mag_reg <= cfg_wdata[MAG_W-1:0];
                REG_TYPE_EN:   type_en_reg   <= cfg_wdata;
                REG_NEWTON:    newton_reg    <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    bpf_front #(
        .NUM_BOND_TYPES(NUM_BOND_TYPES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .force_mag(force_mag_reg),
        .type_en  (type_en_reg),
        .newton   (newton_reg),
        .ctl_o    (ctl_c)
    );

    // squares, then sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_d_reg.valid <= 1'b0;
            ctl_e_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_d_reg.valid <= ctl_c.valid;
            ctl_e_reg.valid <= ctl_d_reg.valid;
        end
        if (en) begin
            ctl_d_reg.active  <= ctl_c.active;
            ctl_d_reg.apply_i <= ctl_c.apply_i;
            ctl_d_reg.apply_j <= ctl_c.apply_j;
            ctl_d_reg.zero    <= ctl_c.zero;
            ctl_d_reg.sgn     <= ctl_c.sgn;
            ctl_d_reg.mag     <= ctl_c.mag;
            ctl_d_reg.a       <= ctl_c.a;
            for (int k = 0; k < 3; k++) begin
                sq_d_reg[k] <= SQ_W'(ctl_c.a[k]) * SQ_W'(ctl_c.a[k]);
            end
            ctl_e_reg.active  <= ctl_d_reg.active;
            ctl_e_reg.apply_i <= ctl_d_reg.apply_i;
            ctl_e_reg.apply_j <= ctl_d_reg.apply_j;
            ctl_e_reg.zero    <= ctl_d_reg.zero;
            ctl_e_reg.sgn     <= ctl_d_reg.sgn;
            ctl_e_reg.mag     <= ctl_d_reg.mag;
            ctl_e_reg.a       <= ctl_d_reg.a;
            sum_e_reg <= SUM_W'(sq_d_reg[0]) + SUM_W'(sq_d_reg[1]) + SUM_W'(sq_d_reg[2]);
        end
    end

    bpf_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_i  (ctl_e_reg),
        .sum_i  (sum_e_reg),
        .ctl_o  (ctl_s),
        .root_o (root_s)
    );

    // numerator |f| * a + r, divisor 2r
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_f_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_f_reg.valid <= ctl_s.valid;
        end
        if (en) begin
            ctl_f_reg.active  <= ctl_s.active;
            ctl_f_reg.apply_i <= ctl_s.apply_i;
            ctl_f_reg.apply_j <= ctl_s.apply_j;
            ctl_f_reg.zero    <= ctl_s.zero;
            ctl_f_reg.sgn     <= ctl_s.sgn;
            ctl_f_reg.mag     <= ctl_s.mag;
            ctl_f_reg.a       <= ctl_s.a;
            div_f_reg         <= {root_s, 1'b0};
            for (int k = 0; k < 3; k++) begin
                num_f_reg[k] <= NUM_W'(ctl_s.mag) * NUM_W'(ctl_s.a[k]) + NUM_W'(root_s);
            end
        end
    end

    bpf_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_i  (ctl_f_reg),
        .num_i  (num_f_reg),
        .div_i  (div_f_reg),
        .ctl_o  (ctl_q),
        .quo_o  (quo_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl_q.valid;
        end
        if (en) begin
            active_reg  <= ctl_q.active;
            apply_i_reg <= ctl_q.apply_i;
            apply_j_reg <= ctl_q.apply_j;
            for (int k = 0; k < 3; k++) begin
                if (!ctl_q.active || ctl_q.zero) begin
                    force_reg[k] <= '0;
                end else if (ctl_q.sgn[k]) begin
                    force_reg[k] <= POS_W'(-{1'b0, quo_q[k]});
                end else begin
                    force_reg[k] <= {1'b0, quo_q[k]};
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, apply_j_reg, apply_i_reg, active_reg,
                       force_reg[2], force_reg[1], force_reg[0]};

endmodule

// ===== rtl/core/bpf_front.sv =====
module bpf_front #(
    parameter int NUM_BOND_TYPES = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [bpf_pkg::IN_W-1:0]  in_data,
    input  logic [bpf_pkg::MAG_W-1:0] force_mag,
    input  logic [bpf_pkg::CFG_W-1:0] type_en,
    input  logic                      newton,
    output bpf_pkg::bpf_ctl_t         ctl_o
);
    import bpf_pkg::*;

    logic [POS_W-1:0]  pos_i [3];
    logic [POS_W-1:0]  pos_j [3];
    logic [TAG_W-1:0]  tag_i, tag_j;
    logic [TYPE_W-1:0] btype, btype_m1;
    logic              grp, own_i, own_j, type_ok, active;
    logic [DIFF_W-1:0] diff [3];
    logic [2:0]        neg;
    logic              tag_neg, mag_neg;

    // stage a
    logic              va_reg, act_a_reg, api_a_reg, apj_a_reg;
    logic [2:0]        sgn_a_reg;
    logic [MAG_W-1:0]  mag_a_reg;
    logic [DIFF_W-1:0] abs_a_reg [3];

    // stage b
    logic              vb_reg, act_b_reg, api_b_reg, apj_b_reg, zero_b_reg, right_b_reg;
    logic [2:0]        sgn_b_reg;
    logic [MAG_W-1:0]  mag_b_reg;
    logic [DIFF_W-1:0] abs_b_reg [3];
    logic [1:0]        rsh_b_reg;
    logic [4:0]        lsh_b_reg;
    logic [DIFF_W-1:0] m_max;
    logic [5:0]        msb_pos;

    bpf_ctl_t          ctl_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_i[k] = in_data[k*POS_W +: POS_W];
            pos_j[k] = in_data[(k+3)*POS_W +: POS_W];
            diff[k]  = {pos_i[k][POS_W-1], pos_i[k]} - {pos_j[k][POS_W-1], pos_j[k]};
            neg[k]   = diff[k][DIFF_W-1];
        end
        tag_i    = in_data[192 +: TAG_W];
        tag_j    = in_data[223 +: TAG_W];
        btype    = in_data[254 +: TYPE_W];
        grp      = in_data[261];
        own_i    = in_data[262];
        own_j    = in_data[263];
        btype_m1 = btype - TYPE_W'(1);
        type_ok  = (btype != '0) && (btype <= TYPE_W'(NUM_BOND_TYPES));
        active   = grp && type_ok && type_en[btype_m1[5:0]];
        tag_neg  = !(tag_i > tag_j);
        mag_neg  = force_mag[MAG_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
        if (en) begin
            act_a_reg <= active;
            api_a_reg <= active && (newton || own_i);
            apj_a_reg <= active && (newton || own_j);
            mag_a_reg <= mag_neg ? MAG_W'(-force_mag) : force_mag;
            for (int k = 0; k < 3; k++) begin
                sgn_a_reg[k] <= neg[k] ^ tag_neg ^ mag_neg;
                abs_a_reg[k] <= neg[k] ? DIFF_W'(-diff[k]) : diff[k];
            end
        end
    end

    always_comb begin
        m_max = abs_a_reg[0];
        if (abs_a_reg[1] > m_max) m_max = abs_a_reg[1];
        if (abs_a_reg[2] > m_max) m_max = abs_a_reg[2];
        msb_pos = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (m_max[i]) msb_pos = 6'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            act_b_reg   <= act_a_reg;
            api_b_reg   <= api_a_reg;
            apj_b_reg   <= apj_a_reg;
            sgn_b_reg   <= sgn_a_reg;
            mag_b_reg   <= mag_a_reg;
            abs_b_reg   <= abs_a_reg;
            zero_b_reg  <= (m_max == '0);
            right_b_reg <= (msb_pos > 6'(NORM_TOP));
            rsh_b_reg   <= 2'(msb_pos - 6'(NORM_TOP));
            lsh_b_reg   <= 5'(6'(NORM_TOP) - msb_pos);
        end
    end

    // normalize so the largest component lies in [2^29, 2^30)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= vb_reg;
        end
        if (en) begin
            ctl_reg.active  <= act_b_reg;
            ctl_reg.apply_i <= api_b_reg;
            ctl_reg.apply_j <= apj_b_reg;
            ctl_reg.zero    <= zero_b_reg;
            ctl_reg.sgn     <= sgn_b_reg;
            ctl_reg.mag     <= mag_b_reg;
            for (int k = 0; k < 3; k++) begin
                ctl_reg.a[k] <= right_b_reg ? NORM_W'(abs_b_reg[k] >> rsh_b_reg)
                                            : NORM_W'(abs_b_reg[k] << lsh_b_reg);
            end
        end
    end

    assign ctl_o = ctl_reg;

endmodule

// ===== rtl/core/bpf_sqrt.sv =====
module bpf_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  bpf_pkg::bpf_ctl_t          ctl_i,
    input  logic [bpf_pkg::SUM_W-1:0]  sum_i,
    output bpf_pkg::bpf_ctl_t          ctl_o,
    output logic [bpf_pkg::ROOT_W-1:0] root_o
);
    import bpf_pkg::*;

    bpf_ctl_t          ctl_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        bpf_ctl_t          ctl_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rad_in;

        if (i == 0) begin : g_first
            assign ctl_in  = ctl_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = sum_i;
        end else begin : g_next
            assign ctl_in  = ctl_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1-2*i -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[i].valid <= ctl_in.valid;
            end
            if (en) begin
                ctl_reg[i].active  <= ctl_in.active;
                ctl_reg[i].apply_i <= ctl_in.apply_i;
                ctl_reg[i].apply_j <= ctl_in.apply_j;
                ctl_reg[i].zero    <= ctl_in.zero;
                ctl_reg[i].sgn     <= ctl_in.sgn;
                ctl_reg[i].mag     <= ctl_in.mag;
                ctl_reg[i].a       <= ctl_in.a;
                rad_reg[i]         <= rad_in;
                if (rem_sh >= trial) begin
                    rem_reg[i]  <= rem_sh - trial;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= rem_sh;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign ctl_o  = ctl_reg[ROOT_W-1];
    assign root_o = root_reg[ROOT_W-1];

endmodule

// ===== rtl/core/bpf_div.sv =====
module bpf_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  bpf_pkg::bpf_ctl_t               ctl_i,
    input  logic [2:0][bpf_pkg::NUM_W-1:0]  num_i,
    input  logic [bpf_pkg::DIV_W-1:0]       div_i,
    output bpf_pkg::bpf_ctl_t               ctl_o,
    output logic [2:0][bpf_pkg::QUO_W-1:0]  quo_o
);
    import bpf_pkg::*;

    bpf_ctl_t                ctl_reg [QUO_W];
    logic [DIV_W-1:0]        div_reg [QUO_W];
    logic [2:0][NUM_W-1:0]   num_reg [QUO_W];
    logic [2:0][DIV_W-1:0]   rem_reg [QUO_W];
    logic [2:0][QUO_W-1:0]   quo_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        bpf_ctl_t              ctl_in;
        logic [DIV_W-1:0]      div_in;
        logic [2:0][NUM_W-1:0] num_in;
        logic [2:0][DIV_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [2:0][DIV_W:0]   rem_sh;

        if (i == 0) begin : g_first
            assign ctl_in = ctl_i;
            assign div_in = div_i;
            assign num_in = num_i;
            for (genvar k = 0; k < 3; k++) begin : g_init
                assign rem_in[k] = {1'b0, num_i[k][NUM_W-1:QUO_W]};
            end
            assign quo_in = '0;
        end else begin : g_next
            assign ctl_in = ctl_reg[i-1];
            assign div_in = div_reg[i-1];
            assign num_in = num_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign rem_sh[k] = {rem_in[k], num_in[k][QUO_W-1-i]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[i].valid <= ctl_in.valid;
            end
            if (en) begin
                ctl_reg[i].active  <= ctl_in.active;
                ctl_reg[i].apply_i <= ctl_in.apply_i;
                ctl_reg[i].apply_j <= ctl_in.apply_j;
                ctl_reg[i].zero    <= ctl_in.zero;
                ctl_reg[i].sgn     <= ctl_in.sgn;
                ctl_reg[i].mag     <= ctl_in.mag;
                ctl_reg[i].a       <= ctl_in.a;
                div_reg[i]         <= div_in;
                num_reg[i]         <= num_in;
                for (int k = 0; k < 3; k++) begin
                    if (rem_sh[k] >= {1'b0, div_in}) begin
                        rem_reg[i][k] <= DIV_W'(rem_sh[k] - {1'b0, div_in});
                        quo_reg[i][k] <= {quo_in[k][QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg[i][k] <= DIV_W'(rem_sh[k]);
                        quo_reg[i][k] <= {quo_in[k][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign ctl_o = ctl_reg[QUO_W-1];
    assign quo_o = quo_reg[QUO_W-1];

endmodule

// ===== dv/bond_propulsion_force_core_tb.sv =====
`timescale 1ns / 1ps

module bond_propulsion_force_core_tb;
    import bpf_pkg::*;

    typedef struct {
        logic signed [31:0] pos_i [3];
        logic signed [31:0] pos_j [3];
        logic [30:0]        tag_i;
        logic [30:0]        tag_j;
        logic [6:0]         bond_type;
        logic               both_in_group;
        logic               i_owned;
        logic               j_owned;
    } bond_t;

    typedef struct packed {
        logic               apply_j;
        logic               apply_i;
        logic               bond_active;
        logic signed [31:0] force_z;
        logic signed [31:0] force_y;
        logic signed [31:0] force_x;
    } force_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_wr_en;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;

    bond_propulsion_force_core dut (.*);

    // local copy of the register file
    logic signed [31:0] magnitude_q;
    logic [63:0]        type_enable_q;
    logic               newton_q;

    bond_t  pending_bonds[$];
    force_t expected_forces[$];
    int     errors;
    int     max_gap;
    bit     hold_off_req;
    bit     bond_fire;
    bit     force_fire;
    int     idle_cycles;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic force_t calc_force(bond_t b);
        force_t f;
        longint di;
        longint unsigned a [3];
        bit neg [3];
        longint unsigned m;
        longint unsigned r;
        longint unsigned mag;
        longint unsigned q;
        longint fm;
        bit enabled;
        bit s;
        logic signed [31:0] comp [3];
        f = '0;
        enabled = b.bond_type >= 1 && b.bond_type <= 64 && type_enable_q[b.bond_type - 1];
        if (!(b.both_in_group && enabled)) return f;
        f.bond_active = 1'b1;
        f.apply_i = newton_q || b.i_owned;
        f.apply_j = newton_q || b.j_owned;
        m = 0;
        for (int k = 0; k < 3; k++) begin
            di = longint'(b.pos_i[k]) - longint'(b.pos_j[k]);
            neg[k] = di < 0;
            a[k] = neg[k] ? -di : di;
            if (a[k] > m) m = a[k];
        end
        if (m == 0) return f;
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int k = 0; k < 3; k++) a[k] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int k = 0; k < 3; k++) a[k] <<= 1;
        end
        r = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        fm = longint'(magnitude_q);
        mag = fm < 0 ? -fm : fm;
        for (int k = 0; k < 3; k++) begin
            q = (mag * a[k] + r) / (2 * r);
            s = neg[k] ^ !(b.tag_i > b.tag_j) ^ (fm < 0);
            comp[k] = s ? -q[31:0] : q[31:0];
        end
        f.force_x = comp[0];
        f.force_y = comp[1];
        f.force_z = comp[2];
        return f;
    endfunction

    function automatic logic [IN_W-1:0] pack_bond(bond_t b);
        return {b.j_owned, b.i_owned, b.both_in_group, b.bond_type, b.tag_j, b.tag_i,
                b.pos_j[2], b.pos_j[1], b.pos_j[0], b.pos_i[2], b.pos_i[1], b.pos_i[0]};
    endfunction

    // driver
    always @(posedge aclk) begin
        bond_fire <= s_tvalid && s_tready;
        force_fire <= m_tvalid && m_tready;
    end

    int bond_gap;
    always @(negedge aclk) begin
        logic nv;
        bond_t b;
        if (aresetn) begin
            nv = s_tvalid;
            if (bond_fire) nv = 1'b0;
            if (!nv) begin
                if (bond_gap > 0) begin
                    bond_gap--;
                end else if (pending_bonds.size() > 0) begin
                    b = pending_bonds.pop_front();
                    s_tdata <= pack_bond(b);
                    expected_forces.push_back(calc_force(b));
                    nv = 1'b1;
                    bond_gap = $urandom_range(0, max_gap);
                end
            end
            s_tvalid <= nv;
        end
    end

    // receiver, with an occasional long hold-off
    int force_gap;
    int hold_cnt;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off_req && hold_cnt == 0) begin
                hold_cnt = 400;
                hold_off_req = 1'b0;
            end
            if (force_fire) force_gap = $urandom_range(0, max_gap);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (force_gap > 0) begin
                force_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        force_t got;
        force_t exp_f;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[98:0];
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_f = expected_forces.pop_front();
                if (got.force_x !== exp_f.force_x)
                    $display("%0t: force_x exp %h got %h", $time, exp_f.force_x, got.force_x);
                if (got.force_y !== exp_f.force_y)
                    $display("%0t: force_y exp %h got %h", $time, exp_f.force_y, got.force_y);
                if (got.force_z !== exp_f.force_z)
                    $display("%0t: force_z exp %h got %h", $time, exp_f.force_z, got.force_z);
                if (got.bond_active !== exp_f.bond_active)
                    $display("%0t: bond_active exp %b got %b", $time, exp_f.bond_active,
                             got.bond_active);
                if (got.apply_i !== exp_f.apply_i)
                    $display("%0t: apply_i exp %b got %b", $time, exp_f.apply_i, got.apply_i);
                if (got.apply_j !== exp_f.apply_j)
                    $display("%0t: apply_j exp %b got %b", $time, exp_f.apply_j, got.apply_j);
                if (got !== exp_f) errors++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_bonds.size() == 0 && expected_forces.size() == 0 && !s_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FORCE_MAG: magnitude_q = val[31:0];
            REG_TYPE_EN: type_enable_q = val;
            REG_NEWTON: newton_q = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] mag, logic [63:0] en, logic nt);
        write_reg(REG_FORCE_MAG, {32'h0, mag});
        write_reg(REG_TYPE_EN, en);
        write_reg(REG_NEWTON, {63'h0, nt});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bonds.size() > 0 || s_tvalid || expected_forces.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255) << 8;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic bond_t rand_bond();
        bond_t b;
        int sel;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            b.pos_i[k] = rand_pos();
            case (sel)
                0: b.pos_j[k] = b.pos_i[k];
                1, 2, 3: b.pos_j[k] = b.pos_i[k] + $signed($urandom_range(0, 16'hffff))
                                     - 32'sd32768;
                default: b.pos_j[k] = rand_pos();
            endcase
        end
        b.tag_i = 31'($urandom);
        b.tag_j = ($urandom_range(0, 7) == 0) ? b.tag_i : 31'($urandom);
        b.bond_type = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
        b.both_in_group = $urandom_range(0, 7) != 0;
        b.i_owned = 1'($urandom);
        b.j_owned = 1'($urandom);
        return b;
    endfunction

    function automatic bond_t make_bond(logic signed [31:0] dx, logic signed [31:0] dy,
                                        logic signed [31:0] dz, logic [30:0] ti,
                                        logic [30:0] tj, logic [6:0] bt, logic g,
                                        logic oi, logic oj);
        bond_t b;
        b.pos_i[0] = dx; b.pos_i[1] = dy; b.pos_i[2] = dz;
        b.pos_j[0] = 0; b.pos_j[1] = 0; b.pos_j[2] = 0;
        b.tag_i = ti; b.tag_j = tj; b.bond_type = bt;
        b.both_in_group = g; b.i_owned = oi; b.j_owned = oj;
        return b;
    endfunction

    task automatic add_random(int n);
        for (int i = 0; i < n; i++) pending_bonds.push_back(rand_bond());
    endtask

    initial begin
        bond_t b;
        errors = 0;
        max_gap = 12;
        hold_off_req = 0;
        bond_gap = 0;
        force_gap = 0;
        hold_cnt = 0;
        idle_cycles = 0;
        bond_fire = 0;
        force_fire = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        magnitude_q = 0;
        type_enable_q = '1;
        newton_q = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: zero magnitude, all types on
        add_random(20);
        drain();

        configure(32'h0001_0000, 64'hffff_ffff_ffff_ffff, 1'b0);
        // unused register index is ignored
        write_reg(2'd3, 64'hdead_beef_0000_0000);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pending_bonds.push_back(make_bond(32'sh10000, 0, 0, 5, 3, 1, 1, 1, 1));
        pending_bonds.push_back(make_bond(32'sh10000, 0, 0, 3, 5, 64, 1, 0, 1));
        pending_bonds.push_back(make_bond(32'sh10000, 0, 0, 7, 7, 2, 1, 1, 0));
        pending_bonds.push_back(make_bond(0, 0, 0, 9, 1, 3, 1, 1, 1));
        pending_bonds.push_back(make_bond(0, 0, 0, 9, 1, 3, 0, 1, 1));
        pending_bonds.push_back(make_bond(32'sh10000, 32'sh10000, 32'sh10000, 9, 1, 0, 1, 1, 1));
        pending_bonds.push_back(make_bond(32'sh10000, 0, 0, 9, 1, 65, 1, 1, 1));
        pending_bonds.push_back(make_bond(32'sh10000, 0, 0, 9, 1, 127, 1, 1, 1));
        pending_bonds.push_back(make_bond(1, 0, 0, 31'h7fffffff, 0, 1, 1, 1, 1));
        pending_bonds.push_back(make_bond(0, -1, 0, 0, 31'h7fffffff, 1, 1, 1, 1));
        pending_bonds.push_back(make_bond(0, 0, 32'sh7fffffff, 2, 1, 1, 1, 0, 0));
        pending_bonds.push_back(make_bond(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                          2, 1, 1, 1, 0, 0));
        pending_bonds.push_back(make_bond(-3, 4, 0, 2, 1, 1, 1, 0, 0));
        b = make_bond(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 2, 1, 1, 1, 1, 0);
        b.pos_j[0] = 32'sh80000000; b.pos_j[1] = 32'sh7fffffff; b.pos_j[2] = 32'sh80000000;
        pending_bonds.push_back(b);
        add_random(60);
        drain();

        configure(32'h7fff_ffff, 64'h8000_0000_0000_0001, 1'b1);
        add_random(80);
        drain();

        // full rate with a long receiver hold-off
        max_gap = 0;
        configure(32'h8000_0000, 64'h0, 1'b0);
        add_random(20);
        drain();
        configure(32'h8000_0000, 64'hffff_ffff_ffff_ffff, 1'b0);
        hold_off_req = 1'b1;
        add_random(100);
        drain();
        max_gap = 12;

        configure($urandom, {$urandom, $urandom}, 1'b1);
        add_random(80);
        drain();

        configure(32'hffff_0000, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_random(80);
        drain();

        configure($urandom, {$urandom, $urandom}, 1'b0);
        add_random(60);
        drain();

        if (errors == 0 && expected_forces.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
